// ----- sv/scharr_gradient_3x3_assert.svh -----
`ifndef SCHARR_GRADIENT_3X3_ASSERT_SVH
`define SCHARR_GRADIENT_3X3_ASSERT_SVH

// same-cycle implication
`define SCH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scharr port check failed");

// next-cycle implication
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scharr port check failed");

`endif

// ----- sv/scharr_pkg.sv -----
package scharr_pkg;

  localparam int unsigned ROW_BITS        = 16;
  localparam int unsigned WIDTH_REG_BITS  = 12;
  localparam int unsigned HEIGHT_REG_BITS = 16;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS   = 16;

  // register indexes of the config port
  localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRANSPOSED = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT     = 2'd3;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd1;

  // job queue between front and back
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_BITS = 2;
  localparam int unsigned QCNT_BITS = 3;

  // result jobs of one pixel, in emission order
  localparam int unsigned NUM_JOBS      = 4;
  localparam int unsigned JOB_UP_LEFT   = 0;
  localparam int unsigned JOB_UP_EDGE   = 1;
  localparam int unsigned JOB_LAST_LEFT = 2;
  localparam int unsigned JOB_LAST_EDGE = 3;

  typedef struct packed {
    logic [NUM_JOBS-1:0] jobs;
    logic                row_ge1;
    logic                row_ge2;
    logic                col_ge1;
    logic                col_ge2;
    logic                end_row;
    logic                last_row;
    logic [ROW_BITS-1:0] row;
  } job_ctrl_t;

  typedef struct packed {
    logic axis;
    logic transposed;
  } kern_cfg_t;

endpackage

// ----- sv/scharr_gradient_3x3.sv -----
// channel   dir  handshake                       payload
// -------   ---  ------------------------------  --------------------------------------
// pixel     in   push / full                     pixel_i
// result    out  empty / pop                     gradient_o, out_row_o, out_col_o,
//                                                last_of_step_o, frame_done_o
// config    in   cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// one pixel beat per clock while results drain; the back end makes one result per clock,
// so a row end adds a result and the last row of a taller image runs at half rate
// (four results on its final pixel); the 4-entry job queue decouples but hides no cost
// a pixel beat passes the read stage, then the job queue, then the result register
// reset clears counters, window, queue pointers, result valid, config; not line stores
// pop held low stalls the back end; full rises once the job queue has no credit left
module scharr_gradient_3x3 #(
  parameter  int unsigned MAX_WIDTH  = 2048,
  parameter  int unsigned PIXEL_BITS = 16,
  localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH),
  localparam int unsigned GRAD_BITS  = PIXEL_BITS + 5
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel beats
  input  logic                                push,
  output logic                                full,
  input  logic signed [PIXEL_BITS-1:0]        pixel_i,
  // result beats
  output logic                                empty,
  input  logic                                pop,
  output logic signed [GRAD_BITS-1:0]         gradient_o,
  output logic [scharr_pkg::ROW_BITS-1:0]     out_row_o,
  output logic [COL_BITS-1:0]                 out_col_o,
  output logic                                last_of_step_o,
  output logic                                frame_done_o,
  // config writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [scharr_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [scharr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import scharr_pkg::*;

  localparam int unsigned CTRL_BITS = $bits(job_ctrl_t);
  localparam int unsigned WIN_BITS  = 9 * PIXEL_BITS;
  localparam int unsigned Q_BITS    = CTRL_BITS + COL_BITS + WIN_BITS;

  // config registers
  logic                       axis_q, transposed_q;
  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;
  kern_cfg_t                  kcfg;

  // front to queue
  logic                            f_push;
  job_ctrl_t                       f_ctrl;
  logic [COL_BITS-1:0]             f_col;
  logic [2:0][2:0][PIXEL_BITS-1:0] f_win;

  // queue to back
  logic [Q_BITS-1:0]               q_rdata;
  logic                            q_empty, q_pop;
  logic [QCNT_BITS-1:0]            q_count;
  job_ctrl_t                       h_ctrl;
  logic [COL_BITS-1:0]             h_col;
  logic [2:0][2:0][PIXEL_BITS-1:0] h_win;

  // writes are always taken; software must write only while idle, unchecked by the block
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q       <= 1'b0;
      transposed_q <= 1'b0;
      width_q      <= WIDTH_RESET;
      height_q     <= HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_AXIS:       axis_q       <= cfg_data_i[0];
        CFG_TRANSPOSED: transposed_q <= cfg_data_i[0];
        CFG_WIDTH:      width_q      <= cfg_data_i[WIDTH_REG_BITS-1:0];
        CFG_HEIGHT:     height_q     <= cfg_data_i[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign kcfg.axis       = axis_q;
  assign kcfg.transposed = transposed_q;

  // front: raster counters, line stores, window, job classification
  scharr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .pixel_i   (pixel_i),
    .width_i   (width_q),
    .height_i  (height_q),
    .q_count_i (q_count),
    .q_push_o  (f_push),
    .q_ctrl_o  (f_ctrl),
    .q_col_o   (f_col),
    .q_win_o   (f_win)
  );

  // job queue: one entry per pixel that yields results, window snapshot included
  scharr_queue #(
    .DATA_BITS (Q_BITS)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_ctrl, f_col, f_win}),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign {h_ctrl, h_col, h_win} = q_rdata;

  // back: one kernel evaluation per result, into the result register
  scharr_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COL_BITS   (COL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kcfg_i         (kcfg),
    .q_empty_i      (q_empty),
    .q_ctrl_i       (h_ctrl),
    .q_col_i        (h_col),
    .q_win_i        (h_win),
    .q_pop_o        (q_pop),
    .empty_o        (empty),
    .pop_i          (pop),
    .gradient_o     (gradient_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_step_o (last_of_step_o),
    .frame_done_o   (frame_done_o)
  );

endmodule

// ----- sv/scharr_queue.sv -----
module scharr_queue #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [DATA_BITS-1:0]            data_i,
  input  logic                            pop_i,
  output logic [DATA_BITS-1:0]            data_o,
  output logic                            empty_o,
  output logic [scharr_pkg::QCNT_BITS-1:0] count_o
);
  import scharr_pkg::*;

  logic [DATA_BITS-1:0] mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_BITS'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ----- sv/scharr_front.sv -----
module scharr_front #(
  parameter  int unsigned MAX_WIDTH  = 2048,
  parameter  int unsigned PIXEL_BITS = 16,
  localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  output logic                                  full_o,
  input  logic signed [PIXEL_BITS-1:0]          pixel_i,
  input  logic [scharr_pkg::WIDTH_REG_BITS-1:0]  width_i,
  input  logic [scharr_pkg::HEIGHT_REG_BITS-1:0] height_i,
  input  logic [scharr_pkg::QCNT_BITS-1:0]       q_count_i,
  output logic                                  q_push_o,
  output scharr_pkg::job_ctrl_t                 q_ctrl_o,
  output logic [COL_BITS-1:0]                   q_col_o,
  output logic [2:0][2:0][PIXEL_BITS-1:0]       q_win_o
);
  import scharr_pkg::*;

  localparam int unsigned EW_BITS =
    (COL_BITS + 1 > WIDTH_REG_BITS) ? COL_BITS + 1 : WIDTH_REG_BITS;

  logic                       acc;
  logic [COL_BITS-1:0]        col_q, col_d;
  logic [ROW_BITS-1:0]        row_q, row_d;
  logic [EW_BITS-1:0]         ew, col_next;
  logic [HEIGHT_REG_BITS-1:0] eh;
  logic [HEIGHT_REG_BITS:0]   row_next;
  logic                       end_row, last_row;

  // read stage
  logic                  s1_valid_q;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [COL_BITS-1:0]   s1_col_q;
  logic [ROW_BITS-1:0]   s1_row_q;
  logic                  s1_end_q, s1_last_q;
  logic [PIXEL_BITS-1:0] rd_older_q, rd_prior_q;
  logic                  byp_q;
  logic [PIXEL_BITS-1:0] byp_older_q, byp_prior_q;
  logic [PIXEL_BITS-1:0] older_eff, prior_eff;

  logic [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] prior_mem [MAX_WIDTH];

  logic [2:0][2:0][PIXEL_BITS-1:0] win_q, win_d;
  logic [2:0][PIXEL_BITS-1:0]      new_col;
  job_ctrl_t                       ctrl;

  // credit check: an item in the read stage may still land in the queue
  always_comb begin
    if (s1_valid_q) begin
      full_o = (q_count_i >= QCNT_BITS'(QDEPTH - 1));
    end else begin
      full_o = (q_count_i >= QCNT_BITS'(QDEPTH));
    end
  end

  assign acc = push_i && !full_o;

  // raster position and row/frame end
  always_comb begin
    ew = (width_i == '0) ? EW_BITS'(1) : EW_BITS'(width_i);
    if (ew > EW_BITS'(MAX_WIDTH)) begin
      ew = EW_BITS'(MAX_WIDTH);
    end
    eh       = (height_i == '0) ? HEIGHT_REG_BITS'(1) : height_i;
    col_next = EW_BITS'(col_q) + EW_BITS'(1);
    row_next = {1'b0, row_q} + (HEIGHT_REG_BITS + 1)'(1);
    end_row  = (col_next >= ew);
    last_row = (row_next >= {1'b0, eh});
    if (end_row) begin
      col_d = '0;
      row_d = last_row ? '0 : row_next[ROW_BITS-1:0];
    end else begin
      col_d = col_next[COL_BITS-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
        // same-address write in this cycle is not seen by the read
        byp_q <= s1_valid_q && (col_q == s1_col_q);
      end
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q    <= pixel_i;
      s1_col_q    <= col_q;
      s1_row_q    <= row_q;
      s1_end_q    <= end_row;
      s1_last_q   <= last_row;
      byp_older_q <= prior_eff;
      byp_prior_q <= s1_pix_q;
    end
  end

  // line stores: read on accept, shifted down one row in the next cycle
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_older_q <= older_mem[col_q];
      rd_prior_q <= prior_mem[col_q];
    end
    if (s1_valid_q) begin
      older_mem[s1_col_q] <= prior_eff;
      prior_mem[s1_col_q] <= s1_pix_q;
    end
  end

  assign older_eff = byp_q ? byp_older_q : rd_older_q;
  assign prior_eff = byp_q ? byp_prior_q : rd_prior_q;

  // window shift and job classification
  always_comb begin
    new_col = {s1_pix_q, prior_eff, older_eff};
    win_d   = {new_col, win_q[2], win_q[1]};

    ctrl.row_ge1  = (s1_row_q != '0);
    ctrl.row_ge2  = (s1_row_q > ROW_BITS'(1));
    ctrl.col_ge1  = (s1_col_q != '0);
    ctrl.col_ge2  = (s1_col_q > COL_BITS'(1));
    ctrl.end_row  = s1_end_q;
    ctrl.last_row = s1_last_q;
    ctrl.row      = s1_row_q;
    ctrl.jobs[JOB_UP_LEFT]   = ctrl.row_ge1 && ctrl.col_ge1;
    ctrl.jobs[JOB_UP_EDGE]   = ctrl.row_ge1 && s1_end_q;
    ctrl.jobs[JOB_LAST_LEFT] = s1_last_q && ctrl.col_ge1;
    ctrl.jobs[JOB_LAST_EDGE] = s1_last_q && s1_end_q;
  end

  assign q_push_o = s1_valid_q && (ctrl.jobs != '0);
  assign q_ctrl_o = ctrl;
  assign q_col_o  = s1_col_q;
  assign q_win_o  = win_d;

endmodule

// ----- sv/scharr_back.sv -----
module scharr_back #(
  parameter  int unsigned PIXEL_BITS = 16,
  parameter  int unsigned COL_BITS   = 11,
  localparam int unsigned GRAD_BITS  = PIXEL_BITS + 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  scharr_pkg::kern_cfg_t              kcfg_i,
  input  logic                               q_empty_i,
  input  scharr_pkg::job_ctrl_t              q_ctrl_i,
  input  logic [COL_BITS-1:0]                q_col_i,
  input  logic [2:0][2:0][PIXEL_BITS-1:0]    q_win_i,
  output logic                               q_pop_o,
  output logic                               empty_o,
  input  logic                               pop_i,
  output logic signed [GRAD_BITS-1:0]        gradient_o,
  output logic [scharr_pkg::ROW_BITS-1:0]    out_row_o,
  output logic [COL_BITS-1:0]                out_col_o,
  output logic                               last_of_step_o,
  output logic                               frame_done_o
);
  import scharr_pkg::*;

  function automatic logic signed [GRAD_BITS-1:0] sext(input logic [PIXEL_BITS-1:0] v);
    sext = GRAD_BITS'(signed'(v));
  endfunction

  logic [NUM_JOBS-1:0] taken_q, pending, sel;
  logic                is_last, go, job_edge, job_lastrow;
  logic [1:0]          cl, cm, cr, iu, im, id;
  logic signed [GRAD_BITS-1:0] pa, pb, pm, na, nb, nm;
  logic signed [GRAD_BITS-1:0] pos_e, neg_e, sum, grad;

  logic                        out_valid_q;
  logic signed [GRAD_BITS-1:0] grad_q;
  logic [ROW_BITS-1:0]         row_q;
  logic [COL_BITS-1:0]         col_q;
  logic                        last_q, frame_q;

  // walk the jobs of the head entry, lowest first
  assign pending = q_ctrl_i.jobs & ~taken_q;
  assign sel     = pending & (~pending + NUM_JOBS'(1));
  assign is_last = ((pending & ~sel) == '0);
  assign go      = !q_empty_i && (!out_valid_q || pop_i);
  assign q_pop_o = go && is_last;

  assign job_edge    = sel[JOB_UP_EDGE] || sel[JOB_LAST_EDGE];
  assign job_lastrow = sel[JOB_LAST_LEFT] || sel[JOB_LAST_EDGE];

  // window taps with border replication
  always_comb begin
    if (job_edge) begin
      cl = q_ctrl_i.col_ge1 ? 2'd1 : 2'd2;
      cm = 2'd2;
    end else begin
      cl = q_ctrl_i.col_ge2 ? 2'd0 : 2'd1;
      cm = 2'd1;
    end
    cr = 2'd2;
    if (job_lastrow) begin
      iu = q_ctrl_i.row_ge1 ? 2'd1 : 2'd2;
      im = 2'd2;
    end else begin
      iu = q_ctrl_i.row_ge2 ? 2'd0 : 2'd1;
      im = 2'd1;
    end
    id = 2'd2;

    if (!kcfg_i.axis) begin
      pa = sext(q_win_i[cl][iu]);
      pb = sext(q_win_i[cl][id]);
      pm = sext(q_win_i[cl][im]);
      na = sext(q_win_i[cr][iu]);
      nb = sext(q_win_i[cr][id]);
      nm = sext(q_win_i[cr][im]);
    end else begin
      pa = sext(q_win_i[cl][iu]);
      pb = sext(q_win_i[cr][iu]);
      pm = sext(q_win_i[cm][iu]);
      na = sext(q_win_i[cl][id]);
      nb = sext(q_win_i[cr][id]);
      nm = sext(q_win_i[cm][id]);
    end

    // 3 * edges + 10 * center, positive side minus negative side
    pos_e = pa + pb;
    neg_e = na + nb;
    sum   = (pos_e <<< 1) + pos_e + (pm <<< 3) + (pm <<< 1)
          - (neg_e <<< 1) - neg_e - (nm <<< 3) - (nm <<< 1);
    grad  = kcfg_i.transposed ? -sum : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      taken_q     <= '0;
    end else begin
      if (go) begin
        out_valid_q <= 1'b1;
        taken_q     <= is_last ? '0 : (taken_q | sel);
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      grad_q  <= grad;
      row_q   <= job_lastrow ? q_ctrl_i.row : q_ctrl_i.row - ROW_BITS'(1);
      col_q   <= job_edge ? q_col_i : q_col_i - COL_BITS'(1);
      last_q  <= is_last;
      frame_q <= is_last && q_ctrl_i.last_row && q_ctrl_i.end_row;
    end
  end

  assign empty_o        = !out_valid_q;
  assign gradient_o     = grad_q;
  assign out_row_o      = row_q;
  assign out_col_o      = col_q;
  assign last_of_step_o = last_q;
  assign frame_done_o   = frame_q;

endmodule

// ----- sv/scharr_checker.sv -----
`include "scharr_gradient_3x3_assert.svh"

module scharr_checker #(
  parameter int unsigned GRAD_BITS = 21,
  parameter int unsigned COL_BITS  = 11
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             empty,
  input logic                             pop,
  input logic signed [GRAD_BITS-1:0]      gradient_o,
  input logic [scharr_pkg::ROW_BITS-1:0]  out_row_o,
  input logic [COL_BITS-1:0]              out_col_o,
  input logic                             last_of_step_o,
  input logic                             frame_done_o
);

  // a waiting result holds until taken
  `SCH_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(gradient_o) && $stable(out_row_o) && $stable(out_col_o) && $stable(last_of_step_o) && $stable(frame_done_o))

  // the image end is always the last result of its pixel
  `SCH_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, !empty && frame_done_o, last_of_step_o)

  // results of one pixel come out back to back
  `SCH_ASSERT_NEXT(a_step_contiguous, clk_i, rst_ni, !empty && pop && !last_of_step_o, !empty)

endmodule

bind scharr_gradient_3x3 scharr_checker #(
  .GRAD_BITS (GRAD_BITS),
  .COL_BITS  (COL_BITS)
) u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .gradient_o     (gradient_o),
  .out_row_o      (out_row_o),
  .out_col_o      (out_col_o),
  .last_of_step_o (last_of_step_o),
  .frame_done_o   (frame_done_o)
);
